// File: hw/rtl/rar_pkg.sv
// Shared types and constants for the rational arithmetic reduction core.
`timescale 1ns / 1ps

package rar_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_ADD = 2'd0;
  localparam mode_t MODE_SUB = 2'd1;
  localparam mode_t MODE_MUL = 2'd2;
  localparam mode_t MODE_DIV = 2'd3;

  localparam int NUM_W = 33;
  localparam int DEN_W = 32;

endpackage

// File: hw/rtl/rar_if.sv
// Request and result channel interfaces of the rational arithmetic reduction core.
`timescale 1ns / 1ps

interface rar_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  rar_pkg::mode_t      mode;
  logic signed [W-1:0] a_num;
  logic signed [W-1:0] a_den;
  logic signed [W-1:0] b_num;
  logic signed [W-1:0] b_den;

  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [rar_pkg::NUM_W-1:0] res_num;
  logic signed [rar_pkg::DEN_W-1:0] res_den;

  modport source (output valid, res_num, res_den, input ready);
  modport sink (input valid, res_num, res_den, output ready);
endinterface

// File: hw/rtl/rational_arith_reduce_core.sv
// Rational add, subtract, multiply and divide with gcd reduction on a shared iterative datapath.
// A request runs through three multiply states, the add, a zero check, the binary gcd loop,
// and a one-bit shift-subtract divider that divides numerator and then denominator by the gcd.
// The gcd loop is skipped when a raw part is zero; both parts zero skip the divider as well.
// One request is in work at a time; the next is taken the cycle after its result is loaded.
// Reset (synchronous, active high) returns the sequencer to idle and drops the result valid.
`timescale 1ns / 1ps

module rational_arith_reduce_core #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic       clk,
  input logic       rst,
  rar_in_if.sink    operands,
  rar_out_if.source results
);

  localparam int W  = OPERAND_WIDTH;
  localparam int MW = 2 * OPERAND_WIDTH;
  localparam int XW = (MW + 1 > rar_pkg::NUM_W) ? MW + 1 : rar_pkg::NUM_W;
  localparam int CW = $clog2(MW + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL0 = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_ADD  = 4'd4;
  localparam logic [3:0] S_CHK  = 4'd5;
  localparam logic [3:0] S_GCD  = 4'd6;
  localparam logic [3:0] S_DIVN = 4'd7;
  localparam logic [3:0] S_DIVD = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0]           state;
  rar_pkg::mode_t       op_mode;
  logic [W-1:0]         an_m, ad_m, bn_m, bd_m;
  logic                 an_s, ad_s, bn_s, bd_s;
  logic [MW-1:0]        t1, t2;
  logic                 t1_neg, t2_neg;
  logic [MW-1:0]        nm, dm;
  logic                 num_neg, den_neg;
  logic [MW-1:0]        x, y;
  logic [MW-1:0]        dv_rem, dv_quo;
  logic [CW-1:0]        cnt;
  logic                 res_valid;
  logic [rar_pkg::NUM_W-1:0] res_num;
  logic [rar_pkg::DEN_W-1:0] res_den;

  logic [W-1:0]  mul_a, mul_b;
  logic          mul_sa, mul_sb;
  logic [MW-1:0] prod;
  logic          prod_neg;
  logic          add_same, add_ge, sum_neg;
  logic [MW-1:0] sum_mag;
  logic          xy_ge;
  logic [MW-1:0] xy_diff;
  logic [MW:0]   div_shift;
  logic          div_ge;
  logic [MW:0]   div_sub;
  logic [MW-1:0] rem_next, quo_next;
  logic          div_last;
  logic [XW-1:0] ext_n, ext_d, tc_n, tc_d;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
    mag_of = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  always_comb begin
    unique case (state)
      S_MUL0: begin
        mul_a  = an_m;
        mul_sa = an_s;
        mul_b  = (op_mode == rar_pkg::MODE_MUL) ? bn_m : bd_m;
        mul_sb = (op_mode == rar_pkg::MODE_MUL) ? bn_s : bd_s;
      end
      S_MUL1: begin
        mul_a  = bn_m;
        mul_sa = bn_s;
        mul_b  = ad_m;
        mul_sb = ad_s;
      end
      default: begin
        mul_a  = ad_m;
        mul_sa = ad_s;
        mul_b  = (op_mode == rar_pkg::MODE_DIV) ? bn_m : bd_m;
        mul_sb = (op_mode == rar_pkg::MODE_DIV) ? bn_s : bd_s;
      end
    endcase
  end

  assign prod     = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
  assign prod_neg = (prod != '0) && (mul_sa ^ mul_sb);

  assign add_same = (t1_neg == t2_neg);
  assign add_ge   = (t1 >= t2);
  assign sum_mag  = add_same ? (t1 + t2) : (add_ge ? (t1 - t2) : (t2 - t1));
  assign sum_neg  = (sum_mag != '0) && (add_same ? t1_neg : (add_ge ? t1_neg : t2_neg));

  assign xy_ge   = (x >= y);
  assign xy_diff = xy_ge ? (x - y) : (y - x);

  assign div_shift = {dv_rem, dv_quo[MW-1]};
  assign div_ge    = (div_shift >= {1'b0, x});
  assign div_sub   = div_shift - {1'b0, x};
  assign rem_next  = div_ge ? div_sub[MW-1:0] : div_shift[MW-1:0];
  assign quo_next  = {dv_quo[MW-2:0], div_ge};
  assign div_last  = (cnt == CW'(MW - 1));

  assign ext_n = {{(XW - MW){1'b0}}, nm};
  assign ext_d = {{(XW - MW){1'b0}}, dm};
  assign tc_n  = num_neg ? (~ext_n + XW'(1)) : ext_n;
  assign tc_d  = den_neg ? (~ext_d + XW'(1)) : ext_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && state != S_FIN) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (operands.valid) begin
            op_mode <= operands.mode;
            an_m    <= mag_of(operands.a_num);
            ad_m    <= mag_of(operands.a_den);
            bn_m    <= mag_of(operands.b_num);
            bd_m    <= mag_of(operands.b_den);
            an_s    <= operands.a_num[W-1];
            ad_s    <= operands.a_den[W-1];
            bn_s    <= operands.b_num[W-1];
            bd_s    <= operands.b_den[W-1];
            state   <= S_MUL0;
          end
        end
        S_MUL0: begin
          t1     <= prod;
          t1_neg <= prod_neg;
          state  <= S_MUL1;
        end
        S_MUL1: begin
          t2     <= prod;
          t2_neg <= (prod != '0) && (prod_neg ^ (op_mode == rar_pkg::MODE_SUB)) ||
                    (prod != '0) && !prod_neg && (op_mode == rar_pkg::MODE_SUB);
          state  <= S_MUL2;
        end
        S_MUL2: begin
          dm      <= prod;
          den_neg <= prod_neg;
          state   <= S_ADD;
        end
        S_ADD: begin
          if (op_mode == rar_pkg::MODE_ADD || op_mode == rar_pkg::MODE_SUB) begin
            nm      <= sum_mag;
            x       <= sum_mag;
            num_neg <= sum_neg;
          end else begin
            nm      <= t1;
            x       <= t1;
            num_neg <= t1_neg;
          end
          y     <= dm;
          state <= S_CHK;
        end
        S_CHK: begin
          dv_rem <= '0;
          dv_quo <= nm;
          cnt    <= '0;
          priority if (nm == '0 && dm == '0) begin
            dm      <= MW'(1);
            num_neg <= 1'b0;
            den_neg <= 1'b0;
            state   <= S_FIN;
          end else if (nm == '0 || dm == '0) begin
            x     <= nm | dm;
            state <= S_DIVN;
          end else begin
            state <= S_GCD;
          end
        end
        S_GCD: begin
          dv_rem <= '0;
          dv_quo <= nm;
          cnt    <= '0;
          priority if (!x[0] && !y[0]) begin
            x  <= x >> 1;
            y  <= y >> 1;
            nm <= nm >> 1;
            dm <= dm >> 1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x == y) begin
            state <= S_DIVN;
          end else if (xy_ge) begin
            x <= xy_diff >> 1;
          end else begin
            y <= xy_diff >> 1;
          end
        end
        S_DIVN: begin
          if (div_last) begin
            nm     <= quo_next;
            dv_rem <= '0;
            dv_quo <= dm;
            cnt    <= '0;
            state  <= S_DIVD;
          end else begin
            cnt    <= cnt + CW'(1);
            dv_rem <= rem_next;
            dv_quo <= quo_next;
          end
        end
        S_DIVD: begin
          cnt    <= cnt + CW'(1);
          dv_rem <= rem_next;
          dv_quo <= quo_next;
          if (div_last) begin
            dm    <= quo_next;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!res_valid || results.ready) begin
            res_num   <= tc_n[rar_pkg::NUM_W-1:0];
            res_den   <= tc_d[rar_pkg::DEN_W-1:0];
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign operands.ready  = (state == S_IDLE);
  assign results.valid   = res_valid;
  assign results.res_num = res_num;
  assign results.res_den = res_den;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    operands.valid && operands.ready |=> state == S_MUL0)
    else $error("accepted request did not start the multiply sequence");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_GCD |-> (x != '0 && y != '0))
    else $error("gcd operand reached zero");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVN || state == S_DIVD) |-> x != '0)
    else $error("divider started with a zero divisor");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVN || state == S_DIVD) |-> dv_rem < x)
    else $error("partial remainder not below the divisor");

  a_fin_exact: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVD && div_last) |-> rem_next == '0)
    else $error("denominator division left a remainder");

endmodule
